[rtl/sust_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package sust_pkg;
	localparam int CAPACITY_DEF = 256;
	localparam int KEY_BITS_DEF = 32;
	localparam int OP_W = 3;
	localparam int KEY_W = 32;
	localparam int POS_W = 8;
	localparam int STATUS_W = 3;
	localparam int SLOT_W = 8;
	localparam int ENTRIES_W = 9;

	localparam logic [OP_W-1:0] OP_FIND = 3'd0;
	localparam logic [OP_W-1:0] OP_ADD = 3'd1;
	localparam logic [OP_W-1:0] OP_UPDATE = 3'd2;
	localparam logic [OP_W-1:0] OP_DEL_KEY = 3'd3;
	localparam logic [OP_W-1:0] OP_DEL_POS = 3'd4;
	localparam logic [OP_W-1:0] OP_CLEAR = 3'd5;

	localparam logic [STATUS_W-1:0] ST_OK = 3'd0;
	localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd1;
	localparam logic [STATUS_W-1:0] ST_DUPLICATE = 3'd2;
	localparam logic [STATUS_W-1:0] ST_FULL = 3'd3;
	localparam logic [STATUS_W-1:0] ST_BAD_POS = 3'd4;

	// controller -> datapath
	typedef struct packed {
		logic load;       // capture request
		logic srch_init;  // reset search bounds
		logic probe_rd;   // issue read at mid
		logic probe_upd;  // apply compare to bounds
		logic hit_rd;     // read at lo for hit check
		logic hit_chk;    // latch hit
		logic mv_init_up; // set move pointer for insert
		logic mv_init_dn; // set move pointer for delete
		logic mv_rd;      // read source entry
		logic mv_wr;      // write moved entry, step pointer
		logic ins_wr;     // write new key at lo
		logic cnt_inc;
		logic cnt_dec;
		logic cnt_clr;
		logic res_load;
		logic [STATUS_W-1:0] res_status;
		logic res_slot_pos; // slot from position field, else from lo
	} sust_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic [OP_W-1:0] op;
		logic srch_done;
		logic hit;
		logic full;
		logic pos_bad;
		logic mv_up_done;
		logic mv_dn_done;
	} sust_sts_t;
endpackage
`default_nettype wire

[rtl/sust_if.sv]
`timescale 1ns / 1ps
`default_nettype none
interface sust_req_if;
	logic valid;
	logic ready;
	logic [2:0] op;
	logic [31:0] key;
	logic [7:0] position;
	modport source (output valid, op, key, position, input ready);
	modport sink (input valid, op, key, position, output ready);
endinterface

interface sust_rsp_if;
	logic valid;
	logic ready;
	logic [2:0] status;
	logic [7:0] slot;
	logic [8:0] entries;
	modport source (output valid, status, slot, entries, input ready);
	modport sink (input valid, status, slot, entries, output ready);
endinterface
`default_nettype wire

[rtl/sust_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
module sust_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

[rtl/sust_datapath.sv]
`timescale 1ns / 1ps
`default_nettype none
module sust_datapath #(
	parameter int CAPACITY = 256,
	parameter int KEY_BITS = 32
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic [2:0]                in_op,
	input  wire logic [31:0]               in_key,
	input  wire logic [7:0]                in_position,
	input  wire sust_pkg::sust_cmd_t       cmd,
	output sust_pkg::sust_sts_t            sts,
	output logic [2:0]                     res_status,
	output logic [7:0]                     res_slot,
	output logic [8:0]                     res_entries
);
	import sust_pkg::*;
	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int KW = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;

	logic [OP_W-1:0]  op_q;
	logic [KW-1:0]    key_q;
	logic [POS_W-1:0] pos_q;
	logic [CW-1:0]    cnt_q, lo_q, hi_q, mv_q;
	logic [CW-1:0]    mid;
	logic             we;
	logic [AW-1:0]    waddr, raddr;
	logic [KW-1:0]    wdata, rdata;
	logic             up_mv_q;
	logic             hit_q;

	assign mid = lo_q + ((hi_q - lo_q) >> 1);

	always_comb begin
		raddr = '0;
		if (cmd.probe_rd) raddr = mid[AW-1:0];
		if (cmd.hit_rd) raddr = lo_q[AW-1:0];
		if (cmd.mv_rd) raddr = up_mv_q ? AW'(mv_q - CW'(1)) : AW'(mv_q + CW'(1));
	end

	always_comb begin
		we = cmd.mv_wr | cmd.ins_wr;
		waddr = cmd.ins_wr ? lo_q[AW-1:0] : mv_q[AW-1:0];
		wdata = cmd.ins_wr ? key_q : rdata;
	end

	sust_ram #(.WIDTH(KW), .DEPTH(CAPACITY)) u_store (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
	);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q <= in_op;
			key_q <= in_key[KW-1:0];
			pos_q <= in_position;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			lo_q <= '0;
			hi_q <= '0;
			mv_q <= '0;
			up_mv_q <= 1'b0;
			hit_q <= 1'b0;
			res_status <= '0;
			res_slot <= '0;
			res_entries <= '0;
		end else begin
			if (cmd.srch_init) begin
				lo_q <= '0;
				hi_q <= cnt_q;
			end
			if (cmd.probe_upd) begin
				if (rdata < key_q) lo_q <= mid + CW'(1);
				else hi_q <= mid;
			end
			if (cmd.hit_chk) hit_q <= (lo_q < cnt_q) && (rdata == key_q);
			if (cmd.mv_init_up) begin
				mv_q <= cnt_q;
				up_mv_q <= 1'b1;
			end
			if (cmd.mv_init_dn) begin
				mv_q <= (op_q == OP_DEL_POS) ? CW'(pos_q) : lo_q;
				up_mv_q <= 1'b0;
			end
			if (cmd.mv_wr) mv_q <= up_mv_q ? mv_q - CW'(1) : mv_q + CW'(1);
			if (cmd.cnt_inc) cnt_q <= cnt_q + CW'(1);
			if (cmd.cnt_dec) cnt_q <= cnt_q - CW'(1);
			if (cmd.cnt_clr) cnt_q <= '0;
			if (cmd.res_load) begin
				res_status <= cmd.res_status;
				if (cmd.res_status != ST_OK) res_slot <= '0;
				else if (cmd.res_slot_pos) res_slot <= pos_q;
				else res_slot <= SLOT_W'(lo_q);
				res_entries <= ENTRIES_W'(cnt_q);
			end
		end
	end

	always_comb begin
		sts.op = op_q;
		sts.srch_done = !(lo_q < hi_q);
		sts.hit = hit_q;
		sts.full = (cnt_q >= CW'(CAPACITY));
		sts.pos_bad = !(CW'(pos_q) < cnt_q) || (32'(pos_q) >= CAPACITY);
		sts.mv_up_done = !(mv_q > lo_q);
		sts.mv_dn_done = !((mv_q + CW'(1)) < cnt_q);
	end
endmodule
`default_nettype wire

[rtl/sust_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
module sust_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                req_valid,
	output logic                     req_ready,
	output logic                     rsp_valid,
	input  wire logic                rsp_ready,
	input  wire sust_pkg::sust_sts_t sts,
	output sust_pkg::sust_cmd_t      cmd
);
	import sust_pkg::*;
	localparam logic [3:0] S_IDLE = 4'd0, S_DISP = 4'd1, S_PROBE = 4'd2,
		S_PUPD = 4'd3, S_HRD = 4'd4, S_HCHK = 4'd5, S_DEC = 4'd6,
		S_MRD = 4'd7, S_MWR = 4'd8, S_INS = 4'd9, S_RESP = 4'd10,
		S_SRCH = 4'd11;

	logic [3:0] state_q, state_d;
	logic busy_ok;

	// result buffer is free when nothing is pending or it is being taken
	assign busy_ok = !rsp_valid || rsp_ready;
	assign req_ready = (state_q == S_IDLE);

	always_comb begin
		cmd = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: if (req_valid) begin
				cmd.load = 1'b1;
				state_d = S_DISP;
			end
			S_DISP: begin
				cmd.srch_init = 1'b1;
				case (sts.op)
					OP_FIND, OP_ADD, OP_UPDATE, OP_DEL_KEY: state_d = S_SRCH;
					OP_DEL_POS: if (sts.pos_bad) begin
						cmd.res_status = ST_BAD_POS;
						state_d = S_RESP;
					end else begin
						cmd.mv_init_dn = 1'b1;
						state_d = S_MRD;
					end
					OP_CLEAR: begin
						cmd.cnt_clr = 1'b1;
						state_d = S_RESP;
					end
					default: state_d = S_RESP;
				endcase
			end
			S_SRCH: state_d = sts.srch_done ? S_HRD : S_PROBE;
			S_PROBE: begin
				cmd.probe_rd = 1'b1;
				state_d = S_PUPD;
			end
			S_PUPD: begin
				cmd.probe_upd = 1'b1;
				state_d = S_SRCH;
			end
			S_HRD: begin
				cmd.hit_rd = 1'b1;
				state_d = S_HCHK;
			end
			S_HCHK: begin
				cmd.hit_chk = 1'b1;
				state_d = S_DEC;
			end
			S_DEC: begin
				state_d = S_RESP;
				case (sts.op)
					OP_ADD: if (sts.hit) cmd.res_status = ST_DUPLICATE;
					else if (sts.full) cmd.res_status = ST_FULL;
					else begin
						cmd.mv_init_up = 1'b1;
						state_d = S_MRD;
					end
					OP_DEL_KEY: if (!sts.hit) cmd.res_status = ST_NOT_FOUND;
					else begin
						cmd.mv_init_dn = 1'b1;
						state_d = S_MRD;
					end
					default: if (!sts.hit) cmd.res_status = ST_NOT_FOUND;
				endcase
			end
			S_MRD: begin
				if (sts.op == OP_ADD ? sts.mv_up_done : sts.mv_dn_done) begin
					state_d = S_INS;
				end else begin
					cmd.mv_rd = 1'b1;
					state_d = S_MWR;
				end
			end
			S_MWR: begin
				cmd.mv_wr = 1'b1;
				state_d = S_MRD;
			end
			S_INS: begin
				if (sts.op == OP_ADD) begin
					cmd.ins_wr = 1'b1;
					cmd.cnt_inc = 1'b1;
				end else begin
					cmd.cnt_dec = 1'b1;
				end
				state_d = S_RESP;
			end
			S_RESP: if (busy_ok) begin
				cmd.res_load = 1'b1;
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
		// status chosen on the way into S_RESP is held in status_q of the top level
		cmd.res_slot_pos = (sts.op == OP_DEL_POS);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			rsp_valid <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.res_load) rsp_valid <= 1'b1;
			else if (rsp_ready) rsp_valid <= 1'b0;
		end
	end
endmodule
`default_nettype wire

[rtl/sorted_unique_set_table_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// Channel  Dir  Payload
// req      in   op, key, position
// rsp      out  status, slot, entries
//
// One request at a time. Each binary-search probe checks the bounds, issues
// a RAM read and then applies the bound update. Add/delete move entries one
// at a time, each read then written on the key RAM. Clear and unknown ops
// skip the search and go straight to the response state.
// Reset clears the count and the controller; the key RAM is not cleared.
// The response register holds a result until taken; the next request is
// accepted once the result is loaded.
module sorted_unique_set_table_unit #(
	parameter int CAPACITY = sust_pkg::CAPACITY_DEF,
	parameter int KEY_BITS = sust_pkg::KEY_BITS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	sust_req_if.sink   req,
	sust_rsp_if.source rsp
);
	import sust_pkg::*;

	sust_cmd_t cmd, cmd_fix;
	sust_sts_t sts;
	logic [STATUS_W-1:0] status_q;

	sust_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req.valid), .req_ready(req.ready),
		.rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
		.sts(sts), .cmd(cmd)
	);

	// the status decided on entry to the response state is kept here so
	// the response load can wait on a stalled output
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) status_q <= ST_OK;
		else if (req.valid && req.ready) status_q <= ST_OK;
		else if (cmd.res_status != ST_OK) status_q <= cmd.res_status;
	end

	always_comb begin
		cmd_fix = cmd;
		cmd_fix.res_status = status_q;
	end

	sust_datapath #(.CAPACITY(CAPACITY), .KEY_BITS(KEY_BITS)) u_dp (
		.clk(clk), .arst_n(arst_n),
		.in_op(req.op), .in_key(req.key), .in_position(req.position),
		.cmd(cmd_fix), .sts(sts),
		.res_status(rsp.status), .res_slot(rsp.slot), .res_entries(rsp.entries)
	);
endmodule
`default_nettype wire
